>>> rtl/core/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("assertion failed");

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) \
    else $error("assertion failed");

`endif

>>> rtl/core/ntpm_pkg.sv
package ntpm_pkg;

  localparam int MAX_ENTRIES = 4096;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int TIME_BITS   = 40;
  localparam int MASS_BITS   = 48;
  localparam int TOL_W       = 40;
  localparam int CFG_W       = 40;
  localparam int CFG_IDX_W   = 1;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1000);
  localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ENTRIES);

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    RD_MID,
    RD_LO,
    RD_LAST,
    RD_PREV
  } rd_sel_t;

  typedef struct packed {
    logic    load_we;
    logic    start;
    logic    step;
    logic    take_cand;
    logic    take_prev;
    logic    out_load;
    rd_sel_t rd_sel;
  } ntpm_cmd_t;

  typedef struct packed {
    logic empty;
    logic more;
    logic beyond;
    logic lo_zero;
  } ntpm_sts_t;

endpackage

>>> rtl/core/ntpm_in_if.sv
interface ntpm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [ntpm_pkg::IDX_W-1:0]     entry_index;
  logic [ntpm_pkg::TIME_BITS-1:0] entry_time;
  logic [ntpm_pkg::MASS_BITS-1:0] entry_mass;
  logic [ntpm_pkg::TIME_BITS-1:0] query_time;

  modport source (
    output valid, op, entry_index, entry_time, entry_mass, query_time,
    input  ready
  );

  modport sink (
    input  valid, op, entry_index, entry_time, entry_mass, query_time,
    output ready
  );
endinterface

>>> rtl/core/ntpm_out_if.sv
interface ntpm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [ntpm_pkg::IDX_W-1:0]     match_index;
  logic [ntpm_pkg::TIME_BITS-1:0] match_time;
  logic [ntpm_pkg::MASS_BITS-1:0] match_mass;

  modport source (
    output valid, found, match_index, match_time, match_mass,
    input  ready
  );

  modport sink (
    input  valid, found, match_index, match_time, match_mass,
    output ready
  );
endinterface

>>> rtl/core/nearest_time_peak_matcher.sv
// nearest_time_peak_matcher: nearest-time lookup in a sorted table of peaks
//
// in_ch carries items with valid/ready. op load writes time and mass at
// entry_index and gives no result. op query searches the first
// entry_count entries (at most 4096) for the entry nearest query_time.
// out_ch carries one result per query: found, index, time and mass, all
// zero when the nearest entry is not strictly within match_tolerance.
// cfg_we/cfg_index/cfg_wdata write match_tolerance (0) and entry_count (1).
// A query is accepted, then takes up to ceil(log2(n+1)) binary search steps
// for n entries (13 for a full table), then fetches and compares the
// neighbors (just one when no entry lies on one side of query_time)
// and loads the output register; an empty table goes straight to the load.
// The pace is set by the single read port of the peak table, one read per
// cycle. The output register lets a new item be taken while a result waits;
// a stalled receiver holds the next query in its final step until taken.
// Synchronous reset clears control, sets the tolerance to 1000 and the
// count to 0; table contents are undefined until loaded.
`include "assert_macros.svh"

module nearest_time_peak_matcher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ntpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ntpm_pkg::CFG_W-1:0]     cfg_wdata,
  ntpm_in_if.sink                        in_ch,
  ntpm_out_if.source                     out_ch
);

  ntpm_pkg::ntpm_cmd_t cmd;
  ntpm_pkg::ntpm_sts_t sts;
  logic                in_ready;
  logic                out_valid;

  ntpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ntpm_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .entry_index (in_ch.entry_index),
    .entry_time  (in_ch.entry_time),
    .entry_mass  (in_ch.entry_mass),
    .query_time  (in_ch.query_time),
    .cmd         (cmd),
    .sts         (sts),
    .found       (out_ch.found),
    .match_index (out_ch.match_index),
    .match_time  (out_ch.match_time),
    .match_mass  (out_ch.match_mass)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  `ASSERT_RST(a_query_busy, clk, rst_n,
    in_ch.valid && in_ch.ready && (in_ch.op == ntpm_pkg::OP_QUERY) |=> !in_ch.ready)
  `ASSERT_RST(a_miss_zero, clk, rst_n,
    out_ch.valid && !out_ch.found |-> (out_ch.match_index == '0) &&
      (out_ch.match_time == '0) && (out_ch.match_mass == '0))
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_ch.valid && in_ch.ready)

endmodule

>>> rtl/core/ntpm_datapath.sv
module ntpm_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ntpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ntpm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [ntpm_pkg::IDX_W-1:0]     entry_index,
  input  logic [ntpm_pkg::TIME_BITS-1:0] entry_time,
  input  logic [ntpm_pkg::MASS_BITS-1:0] entry_mass,
  input  logic [ntpm_pkg::TIME_BITS-1:0] query_time,
  input  ntpm_pkg::ntpm_cmd_t            cmd,
  output ntpm_pkg::ntpm_sts_t            sts,
  output logic                           found,
  output logic [ntpm_pkg::IDX_W-1:0]     match_index,
  output logic [ntpm_pkg::TIME_BITS-1:0] match_time,
  output logic [ntpm_pkg::MASS_BITS-1:0] match_mass
);

  logic [ntpm_pkg::TIME_BITS-1:0] mem_time [ntpm_pkg::MAX_ENTRIES];
  logic [ntpm_pkg::MASS_BITS-1:0] mem_mass [ntpm_pkg::MAX_ENTRIES];

  logic [ntpm_pkg::TOL_W-1:0]     tol_r;
  logic [ntpm_pkg::CNT_W-1:0]     count_r;
  logic [ntpm_pkg::CNT_W-1:0]     n_r;
  logic [ntpm_pkg::CNT_W-1:0]     lo_r, hi_r;
  logic [ntpm_pkg::TIME_BITS-1:0] q_r;
  logic [ntpm_pkg::IDX_W-1:0]     rd_addr_r;
  logic [ntpm_pkg::TIME_BITS-1:0] rd_time_r;
  logic [ntpm_pkg::MASS_BITS-1:0] rd_mass_r;
  logic [ntpm_pkg::IDX_W-1:0]     cand_idx_r;
  logic [ntpm_pkg::TIME_BITS-1:0] cand_time_r;
  logic [ntpm_pkg::MASS_BITS-1:0] cand_mass_r;
  logic [ntpm_pkg::TIME_BITS-1:0] gap_r;
  logic                           found_r;
  logic [ntpm_pkg::IDX_W-1:0]     match_index_r;
  logic [ntpm_pkg::TIME_BITS-1:0] match_time_r;
  logic [ntpm_pkg::MASS_BITS-1:0] match_mass_r;

  logic [ntpm_pkg::CNT_W-1:0]     n_clamp;
  logic [ntpm_pkg::CNT_W-1:0]     mid_ext;
  logic                           below;
  logic [ntpm_pkg::CNT_W-1:0]     lo_nxt, hi_nxt, span, mid_nxt;
  logic [ntpm_pkg::IDX_W-1:0]     rd_addr;
  logic [ntpm_pkg::TIME_BITS-1:0] gap_new;
  logic                           in_range;

  assign n_clamp  = (count_r > ntpm_pkg::CNT_MAX) ? ntpm_pkg::CNT_MAX : count_r;
  assign mid_ext  = {1'b0, rd_addr_r};
  assign below    = rd_time_r < q_r;
  assign gap_new  = (rd_time_r >= q_r) ? (rd_time_r - q_r) : (q_r - rd_time_r);
  assign in_range = {1'b0, entry_index} < ntpm_pkg::CNT_MAX;

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    if (cmd.start) begin
      lo_nxt = '0;
      hi_nxt = n_clamp;
    end else if (cmd.step) begin
      if (below) begin
        lo_nxt = mid_ext + ntpm_pkg::CNT_W'(1);
      end else begin
        hi_nxt = mid_ext;
      end
    end
    span    = hi_nxt - lo_nxt;
    mid_nxt = lo_nxt + (span >> 1);
  end

  always_comb begin
    case (cmd.rd_sel)
      ntpm_pkg::RD_MID:  rd_addr = mid_nxt[ntpm_pkg::IDX_W-1:0];
      ntpm_pkg::RD_LO:   rd_addr = lo_nxt[ntpm_pkg::IDX_W-1:0];
      ntpm_pkg::RD_LAST: rd_addr = n_r[ntpm_pkg::IDX_W-1:0] - ntpm_pkg::IDX_W'(1);
      ntpm_pkg::RD_PREV: rd_addr = lo_r[ntpm_pkg::IDX_W-1:0] - ntpm_pkg::IDX_W'(1);
      default:           rd_addr = mid_nxt[ntpm_pkg::IDX_W-1:0];
    endcase
  end

  assign sts.empty   = (n_clamp == '0);
  assign sts.more    = (lo_nxt < hi_nxt);
  assign sts.beyond  = (lo_nxt >= n_r);
  assign sts.lo_zero = (lo_r == '0);

  // peak table
  always_ff @(posedge clk) begin
    if (cmd.load_we && in_range) begin
      mem_time[entry_index] <= entry_time;
      mem_mass[entry_index] <= entry_mass;
    end
    rd_time_r <= mem_time[rd_addr];
    rd_mass_r <= mem_mass[rd_addr];
    rd_addr_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= ntpm_pkg::TOL_RESET;
      count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ntpm_pkg::CFG_TOL:   tol_r   <= cfg_wdata[ntpm_pkg::TOL_W-1:0];
        ntpm_pkg::CFG_COUNT: count_r <= cfg_wdata[ntpm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    if (cmd.start) begin
      q_r   <= query_time;
      n_r   <= n_clamp;
      gap_r <= '1;
    end
    if (cmd.take_cand || (cmd.take_prev && (gap_r > gap_new))) begin
      cand_idx_r  <= rd_addr_r;
      cand_time_r <= rd_time_r;
      cand_mass_r <= rd_mass_r;
      gap_r       <= gap_new;
    end
    if (cmd.out_load) begin
      found_r       <= gap_r < tol_r;
      match_index_r <= (gap_r < tol_r) ? cand_idx_r  : '0;
      match_time_r  <= (gap_r < tol_r) ? cand_time_r : '0;
      match_mass_r  <= (gap_r < tol_r) ? cand_mass_r : '0;
    end
  end

  assign found       = found_r;
  assign match_index = match_index_r;
  assign match_time  = match_time_r;
  assign match_mass  = match_mass_r;

endmodule

>>> rtl/core/ntpm_ctrl.sv
module ntpm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ntpm_pkg::ntpm_sts_t sts,
  output ntpm_pkg::ntpm_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_LAST,
    ST_CAND,
    ST_PREV,
    ST_JUDGE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.rd_sel    = ntpm_pkg::RD_MID;
    in_ready      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == ntpm_pkg::OP_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = sts.empty ? ST_JUDGE : ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.more) begin
          cmd.rd_sel = ntpm_pkg::RD_MID;
        end else if (sts.beyond) begin
          cmd.rd_sel = ntpm_pkg::RD_LAST;
          state_nxt  = ST_LAST;
        end else begin
          cmd.rd_sel = ntpm_pkg::RD_LO;
          state_nxt  = ST_CAND;
        end
      end
      ST_LAST: begin
        cmd.take_cand = 1'b1;
        state_nxt     = ST_JUDGE;
      end
      ST_CAND: begin
        cmd.take_cand = 1'b1;
        if (sts.lo_zero) begin
          state_nxt = ST_JUDGE;
        end else begin
          cmd.rd_sel = ntpm_pkg::RD_PREV;
          state_nxt  = ST_PREV;
        end
      end
      ST_PREV: begin
        cmd.take_prev = 1'b1;
        state_nxt     = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
